### hw/rtl/nstp_pkg.sv
// ----------------------------------------------------------------------------
// nstp_pkg
// Shared types, codes and arithmetic helpers of the section time profiler.
// ----------------------------------------------------------------------------
package nstp_pkg;

    localparam int MAX_SECTIONS_DEF   = 24;
    localparam int MAX_NAMES_DEF      = 24;
    localparam int TS_W               = 64;
    localparam int NAME_W             = 5;
    localparam int FRAMES_W           = 16;
    localparam int DROP_W             = 32;
    localparam int VBITS_W            = 7;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;
    localparam logic [VBITS_W-1:0]  VBITS_RESET = 7'd64;
    localparam logic [FRAMES_W-1:0] SUMF_RESET  = 16'd120;

    typedef enum logic [1:0] {
        FUNC_BEGIN_FRAME = 2'd0,
        FUNC_BEGIN_SEC   = 2'd1,
        FUNC_END_SEC     = 2'd2,
        FUNC_END_FRAME   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_LINE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_VALID_BITS = 2'd1,
        CFG_SUM_FRAMES = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_DLT,
        ST_POP_ACC,
        ST_FRAME,
        ST_FRAME_ADD,
        ST_FRAME_ACK,
        ST_SUM_HDR,
        ST_SCAN,
        ST_LINE
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [NAME_W-1:0] name_id;
        logic [TS_W-1:0]   timestamp;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [NAME_W-1:0]   section_name;
        logic [TS_W-1:0]     ticks;
        logic [FRAMES_W-1:0] frame_count;
        logic                last;
    } out_beat_t;

    typedef struct packed {
        logic [TS_W-1:0]     total;
        logic [FRAMES_W-1:0] frames;
        logic [FRAMES_W-1:0] last_frame;
    } name_entry_t;

    function automatic logic [TS_W-1:0] ts_mask(input logic [VBITS_W-1:0] vb);
        logic [TS_W-1:0] m;
        begin
            if (vb >= VBITS_W'(TS_W))
                m = '1;
            else
                m = (TS_W'(1) << vb) - TS_W'(1);
            return m;
        end
    endfunction

    function automatic logic [TS_W-1:0] masked_delta(input logic [TS_W-1:0] start,
                                                     input logic [TS_W-1:0] stop,
                                                     input logic [VBITS_W-1:0] vb);
        logic [TS_W-1:0] m;
        begin
            m = ts_mask(vb);
            return ((stop & m) - (start & m)) & m;
        end
    endfunction

    function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
                                                input logic [TS_W-1:0] b);
        logic [TS_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[TS_W] ? '1 : s[TS_W-1:0];
        end
    endfunction

endpackage

### hw/rtl/nested_section_time_profiler_core.sv
// ----------------------------------------------------------------------------
// nested_section_time_profiler_core
// Frame and nested section profiler with periodic per-name summaries.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one event beat (func, name_id, timestamp) per item.
//   cfg_*  : register writes (enable, valid_bits, summary_frames), always ready.
//   out_*  : result beats; each event gives one acknowledge, an end frame that
//            closes a summary period adds a header, a line per top-level name.
//   Begin events, drops and ignored events are answered straight from the
//   execute state; an end section that pops goes through a stack read, the
//   delta and a name read-modify-write. An end frame pops each stray section
//   the same way, then forms the frame delta, adds it and acknowledges; a
//   summary adds a header, a scan over name indices up to the last emitted
//   line, and each emitted line.
//   One event is in flight at a time; in_ready is high only while idle.
//   A stalled out_ready holds the current beat in the output register and
//   freezes the sequencer at its next result.
//   Reset clears all control state, totals and the enable bit; the block
//   ignores events until enable is written.
// ----------------------------------------------------------------------------
module nested_section_time_profiler_core
    import nstp_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
    parameter int MAX_NAMES    = MAX_NAMES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = $clog2(MAX_SECTIONS + 1);
    localparam int SW  = $clog2(MAX_SECTIONS);
    localparam int NIW = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
    localparam int SCW = $clog2(MAX_NAMES + 1);
    localparam int EW  = NAME_W + TS_W;

    state_t state_reg, state_next;

    logic [1:0]          func_reg;
    logic [NAME_W-1:0]   name_reg;
    logic [TS_W-1:0]     ts_reg;

    logic                enable_reg;
    logic [VBITS_W-1:0]  vbits_reg;
    logic [FRAMES_W-1:0] sumf_reg;

    logic [CW-1:0]       open_reg, open_next;
    logic [CW-1:0]       rec_reg, rec_next;
    logic [DROP_W-1:0]   drop_reg, drop_next;
    logic                active_reg, active_next;
    logic [TS_W-1:0]     fstart_reg, fstart_next;
    logic [TS_W-1:0]     ftotal_reg, ftotal_next;
    logic [FRAMES_W-1:0] meas_reg, meas_next;
    logic [TS_W-1:0]     delta_reg, delta_next;
    logic [NAME_W-1:0]   pname_reg, pname_next;
    logic [SCW-1:0]      scan_reg, scan_next;
    logic [MAX_NAMES-1:0] level_reg, level_next;

    logic                out_valid_reg;
    out_beat_t           out_data_reg;
    logic                emit;
    out_beat_t           emit_beat;
    logic                out_free;

    logic [EW-1:0]       stack_mem [MAX_SECTIONS];
    logic [EW-1:0]       stack_rd_reg;
    logic                stack_we;
    logic [SW-1:0]       stack_waddr;
    logic                stack_re;
    logic [SW-1:0]       stack_raddr;
    logic [CW-1:0]       top_idx;

    logic                nt_rd_en;
    logic [NIW-1:0]      nt_rd_addr;
    name_entry_t         nt_rd_data;
    logic                nt_wr_en;
    name_entry_t         nt_wr_data;
    logic                nt_clear;
    logic [MAX_NAMES-1:0] nt_valid;
    logic [MAX_NAMES-1:0] elig;
    logic [MAX_NAMES-1:0] elig_above;
    logic [FRAMES_W:0]    tag;
    logic [FRAMES_W-1:0]  limit;
    logic                 sum_hit;

    nstp_name_table #(
        .MAX_NAMES (MAX_NAMES),
        .NIW       (NIW)
    ) u_name_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (nt_rd_en),
        .rd_addr (nt_rd_addr),
        .rd_data (nt_rd_data),
        .wr_en   (nt_wr_en),
        .wr_addr (NIW'(pname_reg)),
        .wr_data (nt_wr_data),
        .clear   (nt_clear),
        .valid   (nt_valid)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign top_idx = open_reg - CW'(1);
    assign elig    = level_reg & nt_valid;
    assign tag     = {1'b0, meas_reg} + (FRAMES_W+1)'(1);
    assign limit   = (sumf_reg == '0) ? FRAMES_W'(1) : sumf_reg;
    assign sum_hit = (meas_reg >= limit);

    always_comb
    begin
        for (int j = 0; j < MAX_NAMES; j++)
        begin
            elig_above[j] = elig[j] && (j > int'(scan_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= in_data.func;
            name_reg <= (int'(in_data.name_id) < MAX_NAMES) ?
                        in_data.name_id : NAME_W'(MAX_NAMES - 1);
            ts_reg   <= in_data.timestamp;
        end
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= {name_reg, ts_reg};
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
        delta_reg  <= delta_next;
        pname_reg  <= pname_next;
        fstart_reg <= fstart_next;
        if (emit && out_free)
        begin
            out_data_reg <= emit_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            vbits_reg     <= VBITS_RESET;
            sumf_reg      <= SUMF_RESET;
            open_reg      <= '0;
            rec_reg       <= '0;
            drop_reg      <= '0;
            active_reg    <= 1'b0;
            ftotal_reg    <= '0;
            meas_reg      <= '0;
            scan_reg      <= '0;
            level_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            open_reg   <= open_next;
            rec_reg    <= rec_next;
            drop_reg   <= drop_next;
            active_reg <= active_next;
            ftotal_reg <= ftotal_next;
            meas_reg   <= meas_next;
            scan_reg   <= scan_next;
            level_reg  <= level_next;
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:     enable_reg <= cfg_data[0];
                    CFG_VALID_BITS: vbits_reg  <= cfg_data[VBITS_W-1:0];
                    CFG_SUM_FRAMES: sumf_reg   <= cfg_data[FRAMES_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        open_next   = open_reg;
        rec_next    = rec_reg;
        drop_next   = drop_reg;
        active_next = active_reg;
        fstart_next = fstart_reg;
        ftotal_next = ftotal_reg;
        meas_next   = meas_reg;
        delta_next  = delta_reg;
        pname_next  = pname_reg;
        scan_next   = scan_reg;
        level_next  = level_reg;
        emit        = 1'b0;
        emit_beat   = '0;
        emit_beat.kind   = KIND_ACK;
        emit_beat.status = STAT_IGNORED;
        emit_beat.last   = 1'b1;
        stack_we    = 1'b0;
        stack_waddr = open_reg[SW-1:0];
        stack_re    = 1'b0;
        stack_raddr = top_idx[SW-1:0];
        nt_rd_en    = 1'b0;
        nt_rd_addr  = NIW'(stack_rd_reg[TS_W +: NAME_W]);
        nt_wr_en    = 1'b0;
        nt_wr_data  = nt_rd_data;
        nt_clear    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                priority if (!enable_reg)
                begin
                    emit = 1'b1;
                end
                else if (func_reg == FUNC_BEGIN_FRAME)
                begin
                    emit = 1'b1;
                    if (!active_reg)
                    begin
                        emit_beat.status = STAT_OK;
                        if (out_free)
                        begin
                            active_next = 1'b1;
                            fstart_next = ts_reg;
                            open_next   = CW'(1);
                            rec_next    = CW'(1);
                            drop_next   = '0;
                        end
                    end
                end
                else if (!active_reg)
                begin
                    emit = 1'b1;
                end
                else if (func_reg == FUNC_BEGIN_SEC)
                begin
                    emit = 1'b1;
                    if (rec_reg >= CW'(MAX_SECTIONS) || open_reg >= CW'(MAX_SECTIONS))
                    begin
                        emit_beat.status = STAT_DROPPED;
                        if (out_free && drop_reg != '1)
                        begin
                            drop_next = drop_reg + DROP_W'(1);
                        end
                    end
                    else
                    begin
                        emit_beat.status       = STAT_OK;
                        emit_beat.section_name = name_reg;
                        if (out_free)
                        begin
                            stack_we = 1'b1;
                            level_next[NIW'(name_reg)] = (open_reg == CW'(1));
                            open_next = open_reg + CW'(1);
                            rec_next  = rec_reg + CW'(1);
                        end
                    end
                end
                else if (func_reg == FUNC_END_SEC)
                begin
                    if (drop_reg != '0)
                    begin
                        emit = 1'b1;
                        emit_beat.status = STAT_DROPPED;
                        if (out_free)
                        begin
                            drop_next = drop_reg - DROP_W'(1);
                        end
                    end
                    else if (open_reg > CW'(1))
                    begin
                        stack_re   = 1'b1;
                        state_next = ST_POP_DLT;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    drop_next = '0;
                    if (open_reg > CW'(1))
                    begin
                        stack_re   = 1'b1;
                        state_next = ST_POP_DLT;
                    end
                    else
                    begin
                        state_next = ST_FRAME;
                    end
                end
                if (emit && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_POP_DLT:
            begin
                delta_next = masked_delta(stack_rd_reg[TS_W-1:0], ts_reg, vbits_reg);
                pname_next = stack_rd_reg[TS_W +: NAME_W];
                nt_rd_en   = 1'b1;
                state_next = ST_POP_ACC;
            end

            ST_POP_ACC:
            begin
                nt_wr_data.total = sat_add(nt_rd_data.total, delta_reg);
                if ({1'b0, nt_rd_data.last_frame} != tag)
                begin
                    nt_wr_data.last_frame = tag[FRAMES_W-1:0];
                    if (nt_rd_data.frames != '1)
                    begin
                        nt_wr_data.frames = nt_rd_data.frames + FRAMES_W'(1);
                    end
                end
                if (func_reg == FUNC_END_SEC)
                begin
                    emit = 1'b1;
                    emit_beat.status       = STAT_OK;
                    emit_beat.section_name = pname_reg;
                    emit_beat.ticks        = delta_reg;
                    if (out_free)
                    begin
                        nt_wr_en   = 1'b1;
                        open_next  = top_idx;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    nt_wr_en  = 1'b1;
                    open_next = top_idx;
                    if (top_idx > CW'(1))
                    begin
                        stack_re    = 1'b1;
                        stack_raddr = SW'(top_idx - CW'(1));
                        state_next  = ST_POP_DLT;
                    end
                    else
                    begin
                        state_next = ST_FRAME;
                    end
                end
            end

            ST_FRAME:
            begin
                delta_next = masked_delta(fstart_reg, ts_reg, vbits_reg);
                state_next = ST_FRAME_ADD;
            end

            ST_FRAME_ADD:
            begin
                ftotal_next = sat_add(ftotal_reg, delta_reg);
                if (meas_reg != '1)
                begin
                    meas_next = meas_reg + FRAMES_W'(1);
                end
                open_next   = '0;
                rec_next    = '0;
                active_next = 1'b0;
                state_next  = ST_FRAME_ACK;
            end

            ST_FRAME_ACK:
            begin
                emit = 1'b1;
                emit_beat.status = STAT_OK;
                emit_beat.ticks  = delta_reg;
                emit_beat.last   = !(sum_hit && ftotal_reg != '0);
                if (out_free)
                begin
                    priority if (sum_hit && ftotal_reg != '0)
                    begin
                        state_next = ST_SUM_HDR;
                    end
                    else if (sum_hit)
                    begin
                        nt_clear    = 1'b1;
                        meas_next   = '0;
                        ftotal_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SUM_HDR:
            begin
                emit = 1'b1;
                emit_beat.kind        = KIND_HEADER;
                emit_beat.status      = STAT_OK;
                emit_beat.ticks       = ftotal_reg;
                emit_beat.frame_count = meas_reg;
                emit_beat.last        = (elig == '0);
                scan_next             = '0;
                if (out_free)
                begin
                    if (elig == '0)
                    begin
                        nt_clear    = 1'b1;
                        meas_next   = '0;
                        ftotal_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                nt_rd_addr = scan_reg[NIW-1:0];
                if (elig[scan_reg[NIW-1:0]])
                begin
                    nt_rd_en   = 1'b1;
                    state_next = ST_LINE;
                end
                else
                begin
                    scan_next = scan_reg + SCW'(1);
                end
            end

            ST_LINE:
            begin
                emit = 1'b1;
                emit_beat.kind         = KIND_LINE;
                emit_beat.status       = STAT_OK;
                emit_beat.section_name = NAME_W'(scan_reg);
                emit_beat.ticks        = nt_rd_data.total;
                emit_beat.frame_count  = nt_rd_data.frames;
                emit_beat.last         = (elig_above == '0);
                if (out_free)
                begin
                    if (elig_above == '0)
                    begin
                        nt_clear    = 1'b1;
                        meas_next   = '0;
                        ftotal_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + SCW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= CW'(MAX_SECTIONS))
        else $error("open section count past stack depth");

    a_rec_cover: assert property (@(posedge clk) disable iff (!rst_n)
        rec_reg >= open_reg)
        else $error("frame records below open count");

    a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !active_reg) |-> (open_reg == '0))
        else $error("sections open with no active frame");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not dispatched");
`endif

endmodule

### hw/rtl/nstp_name_table.sv
// ----------------------------------------------------------------------------
// nstp_name_table
// Per-name totals in a synchronous memory; entry valid bits stand for the
// cleared value so clearing the table only resets the valid bits.
// ----------------------------------------------------------------------------
module nstp_name_table
    import nstp_pkg::*;
#(
    parameter int MAX_NAMES = MAX_NAMES_DEF,
    parameter int NIW       = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [NIW-1:0]       rd_addr,
    output name_entry_t          rd_data,
    input  logic                 wr_en,
    input  logic [NIW-1:0]       wr_addr,
    input  name_entry_t          wr_data,
    input  logic                 clear,
    output logic [MAX_NAMES-1:0] valid
);

    name_entry_t          mem [MAX_NAMES];
    name_entry_t          rd_raw_reg;
    logic                 rd_valid_reg;
    logic [MAX_NAMES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;
    assign valid   = valid_reg;

endmodule
